FILE: sv/pfbu_pkg.sv
// Package for the particle fixed-boundary update: widths, stage map, register codes, types.
package pfbu_pkg;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned DEF_AXES  = 3;

  localparam int unsigned DW    = 32;  // position, velocity, offset
  localparam int unsigned EW    = 31;  // extent, speed, time step, smoothing length
  localparam int unsigned PW    = 2 * EW;  // speed times time step
  localparam int unsigned BW    = 47;  // wall buffer
  localparam int unsigned CW    = BW + 2;  // signed compare width
  localparam int unsigned HW    = DW + 1;  // upper wall
  localparam int unsigned DSW   = DW + 2;  // distance to wall
  localparam int unsigned RW    = BW + 1;  // divider remainder
  localparam int unsigned QW    = 16;  // quotient bits of the scale
  localparam int unsigned SW    = QW + 1;  // scale, up to 1.0
  localparam int unsigned MW    = DW + SW;  // magnitude times scale
  localparam int unsigned CFG_IW = 3;

  localparam logic [SW-1:0] SCALE_ONE = SW'(1) << QW;

  // Stage map
  localparam int unsigned ST_IN   = 0;  // operands, speed times time step
  localparam int unsigned ST_BUF  = 1;  // wall buffer and upper wall
  localparam int unsigned ST_CMP  = 2;  // clamp, wall rules, distance
  localparam int unsigned ST_CLS  = 3;  // scale class
  localparam int unsigned ST_DIV0 = 4;  // first divider step
  localparam int unsigned ST_MUL  = ST_DIV0 + QW;
  localparam int unsigned ST_OUT  = ST_MUL + 1;
  localparam int unsigned NSTG    = ST_OUT + 1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_OFFSET_Z,
    CFG_EXTENT_X,
    CFG_EXTENT_Y,
    CFG_EXTENT_Z,
    CFG_MAX_SPEED,
    CFG_MAX_TIME_STEP
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SC_ZERO,
    SC_FULL,
    SC_DIV
  } scale_e;

  typedef struct packed {
    logic signed [DW-1:0]  pos;
    logic signed [DW-1:0]  vel;
    logic signed [HW-1:0]  hi;
    logic signed [DSW-1:0] wdist;
    logic                  apply;
    scale_e                kind;
    logic [RW-1:0]         rem;
    logic [QW-1:0]         quo;
    logic [MW-1:0]         mag_prod;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] ln;
    logic [PW-1:0]         spd_prod;
    logic [EW-1:0]         hlen;
    logic [BW-1:0]         bufv;
  } stage_t;

endpackage

FILE: sv/pfbu_in_if.sv
// Particle input channel: position, velocity and smoothing length.
interface pfbu_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  pos_z;
  logic signed [31:0]  vel_x;
  logic signed [31:0]  vel_y;
  logic signed [31:0]  vel_z;
  logic [30:0]         smoothing_length;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, smoothing_length,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, smoothing_length,
    output ready
  );
endinterface

FILE: sv/pfbu_out_if.sv
// Particle result channel: clamped position and damped velocity.
interface pfbu_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  new_pos_x;
  logic signed [31:0]  new_pos_y;
  logic signed [31:0]  new_pos_z;
  logic signed [31:0]  new_vel_x;
  logic signed [31:0]  new_vel_y;
  logic signed [31:0]  new_vel_z;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

FILE: sv/pfbu_cfg_if.sv
// Configuration write channel: register index and write data.
interface pfbu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: sv/particle_fixed_boundary_update_top.sv
// Top level of the particle fixed-boundary update pipeline.
//
//   channel  dir  handshake            payload
//   in_i     in   valid/ready          pos_x..z, vel_x..z, smoothing_length
//   out_o    out  valid/ready          new_pos_x..z, new_vel_x..z
//   cfg_i    in   valid/ready (ready=1) index, data
//
// One particle per cycle while out_o is ready; the pipeline holds the 16 one-bit steps of
// the restoring divider that forms the wall scale, plus clamp, multiply and output.
// Reset clears all stage valid bits and loads the register defaults; no clearing pass.
// Each stage holds only when it is full and the stage after it holds, so bubbles
// close up under back-pressure and an item is taken while a result waits at the output.
module particle_fixed_boundary_update_top
  import pfbu_pkg::*;
#(
  parameter int unsigned AXES = DEF_AXES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfbu_in_if.sink       in_i,
  pfbu_out_if.source    out_o,
  pfbu_cfg_if.sink      cfg_i
);

  logic signed [DW-1:0] offset_q [NUM_LANES];
  logic [EW-1:0]        extent_q [NUM_LANES];
  logic [EW-1:0]        max_speed_q;
  logic [EW-1:0]        max_time_step_q;

  stage_t            stage_d [NSTG];
  stage_t            stage_q [NSTG];
  logic [NSTG-1:0]   vld_q;
  logic [NSTG-1:0]   en;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_LANES; d++) begin
        offset_q[d] <= '0;
        extent_q[d] <= EW'(32'h0001_0000);
      end
      max_speed_q     <= '0;
      max_time_step_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_OFFSET_X:      offset_q[0]     <= cfg_i.data;
        CFG_OFFSET_Y:      offset_q[1]     <= cfg_i.data;
        CFG_OFFSET_Z:      offset_q[2]     <= cfg_i.data;
        CFG_EXTENT_X:      extent_q[0]     <= cfg_i.data[EW-1:0];
        CFG_EXTENT_Y:      extent_q[1]     <= cfg_i.data[EW-1:0];
        CFG_EXTENT_Z:      extent_q[2]     <= cfg_i.data[EW-1:0];
        CFG_MAX_SPEED:     max_speed_q     <= cfg_i.data[EW-1:0];
        CFG_MAX_TIME_STEP: max_time_step_q <= cfg_i.data[EW-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  assign en[NSTG-1] = !vld_q[NSTG-1] || out_o.ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign in_i.ready = en[ST_IN];

  for (genvar k = 0; k < NSTG; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= (k == ST_IN) ? in_i.valid : vld_q[(k == ST_IN) ? ST_IN : k - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // ---------------------------------------------------------------- operand stage
  always_comb begin
    stage_d[ST_IN]           = '0;
    stage_d[ST_IN].ln[0].pos = in_i.pos_x;
    stage_d[ST_IN].ln[1].pos = in_i.pos_y;
    stage_d[ST_IN].ln[2].pos = in_i.pos_z;
    stage_d[ST_IN].ln[0].vel = in_i.vel_x;
    stage_d[ST_IN].ln[1].vel = in_i.vel_y;
    stage_d[ST_IN].ln[2].vel = in_i.vel_z;
    stage_d[ST_IN].hlen      = in_i.smoothing_length;
    stage_d[ST_IN].spd_prod  = PW'(max_speed_q) * PW'(max_time_step_q);
  end

  // ---------------------------------------------------------------- buffer and upper wall
  always_comb begin
    stage_d[ST_BUF]      = stage_q[ST_BUF-1];
    stage_d[ST_BUF].bufv = BW'(stage_q[ST_BUF-1].hlen[EW-1:1])
                         + BW'(stage_q[ST_BUF-1].spd_prod[PW-1:QW]);
    for (int d = 0; d < NUM_LANES; d++) begin
      stage_d[ST_BUF].ln[d].hi = HW'(offset_q[d]) + $signed({2'b00, extent_q[d]});
    end
  end

  // ---------------------------------------------------------------- clamp and wall rules
  always_comb begin
    logic signed [CW-1:0] x_w;
    logic signed [CW-1:0] lo_w;
    logic signed [CW-1:0] hi_w;
    logic signed [CW-1:0] buf_w;
    logic                 left;
    logic                 right;
    stage_d[ST_CMP] = stage_q[ST_CMP-1];
    buf_w = $signed({2'b00, stage_q[ST_CMP-1].bufv});
    for (int d = 0; d < NUM_LANES; d++) begin
      x_w   = CW'(stage_q[ST_CMP-1].ln[d].pos);
      lo_w  = CW'(offset_q[d]);
      hi_w  = CW'(stage_q[ST_CMP-1].ln[d].hi);
      left  = (x_w <= lo_w + buf_w) && stage_q[ST_CMP-1].ln[d].vel[DW-1];
      right = (x_w >= hi_w - buf_w) && !stage_q[ST_CMP-1].ln[d].vel[DW-1]
              && (stage_q[ST_CMP-1].ln[d].vel != '0);
      stage_d[ST_CMP].ln[d].apply = 1'b0;
      if (d < AXES) begin
        // upper wall checked last so it wins
        if (x_w <= lo_w) stage_d[ST_CMP].ln[d].pos = offset_q[d];
        if (x_w >= hi_w) stage_d[ST_CMP].ln[d].pos = stage_q[ST_CMP-1].ln[d].hi[DW-1:0];
        stage_d[ST_CMP].ln[d].apply = left || right;
      end
      if (right) begin
        stage_d[ST_CMP].ln[d].wdist = DSW'(stage_q[ST_CMP-1].ln[d].hi)
                                    - DSW'(stage_q[ST_CMP-1].ln[d].pos);
      end else begin
        stage_d[ST_CMP].ln[d].wdist = DSW'(stage_q[ST_CMP-1].ln[d].pos) - DSW'(offset_q[d]);
      end
    end
  end

  // ---------------------------------------------------------------- scale class
  always_comb begin
    logic [RW-1:0] dist_u;
    stage_d[ST_CLS] = stage_q[ST_CLS-1];
    for (int d = 0; d < NUM_LANES; d++) begin
      dist_u = RW'(stage_q[ST_CLS-1].ln[d].wdist[DSW-2:0]);
      stage_d[ST_CLS].ln[d].rem = dist_u;
      stage_d[ST_CLS].ln[d].quo = '0;
      if (stage_q[ST_CLS-1].bufv == '0 || stage_q[ST_CLS-1].ln[d].wdist <= 0) begin
        stage_d[ST_CLS].ln[d].kind = SC_ZERO;
      end else if (dist_u >= RW'(stage_q[ST_CLS-1].bufv)) begin
        stage_d[ST_CLS].ln[d].kind = SC_FULL;
      end else begin
        stage_d[ST_CLS].ln[d].kind = SC_DIV;
      end
    end
  end

  // ---------------------------------------------------------------- divider, one bit a stage
  for (genvar k = ST_DIV0; k < ST_MUL; k++) begin : g_div
    always_comb begin
      logic [RW-1:0] r2;
      logic [RW:0]   diff;
      stage_d[k] = stage_q[k-1];
      for (int d = 0; d < NUM_LANES; d++) begin
        r2   = {stage_q[k-1].ln[d].rem[RW-2:0], 1'b0};
        diff = {1'b0, r2} - {2'b00, stage_q[k-1].bufv};
        if (!diff[RW]) begin
          stage_d[k].ln[d].rem = diff[RW-1:0];
          stage_d[k].ln[d].quo = {stage_q[k-1].ln[d].quo[QW-2:0], 1'b1};
        end else begin
          stage_d[k].ln[d].rem = r2;
          stage_d[k].ln[d].quo = {stage_q[k-1].ln[d].quo[QW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- magnitude times scale
  always_comb begin
    logic [SW-1:0] scale;
    logic [DW-1:0] mag;
    stage_d[ST_MUL] = stage_q[ST_MUL-1];
    for (int d = 0; d < NUM_LANES; d++) begin
      unique case (stage_q[ST_MUL-1].ln[d].kind)
        SC_ZERO: scale = '0;
        SC_FULL: scale = SCALE_ONE;
        SC_DIV:  scale = {1'b0, stage_q[ST_MUL-1].ln[d].quo};
        default: scale = '0;
      endcase
      mag = stage_q[ST_MUL-1].ln[d].vel[DW-1] ? DW'(-stage_q[ST_MUL-1].ln[d].vel)
                                               : DW'(stage_q[ST_MUL-1].ln[d].vel);
      stage_d[ST_MUL].ln[d].mag_prod = MW'(mag) * MW'(scale);
    end
  end

  // ---------------------------------------------------------------- signed result
  always_comb begin
    logic [DW:0] r;
    stage_d[ST_OUT] = stage_q[ST_OUT-1];
    for (int d = 0; d < NUM_LANES; d++) begin
      r = stage_q[ST_OUT-1].ln[d].mag_prod[MW-1:QW];
      if (stage_q[ST_OUT-1].ln[d].apply) begin
        stage_d[ST_OUT].ln[d].vel = stage_q[ST_OUT-1].ln[d].vel[DW-1] ? DW'(-r) : DW'(r);
      end
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_o.valid     = vld_q[ST_OUT];
  assign out_o.new_pos_x = stage_q[ST_OUT].ln[0].pos;
  assign out_o.new_pos_y = stage_q[ST_OUT].ln[1].pos;
  assign out_o.new_pos_z = stage_q[ST_OUT].ln[2].pos;
  assign out_o.new_vel_x = stage_q[ST_OUT].ln[0].vel;
  assign out_o.new_vel_y = stage_q[ST_OUT].ln[1].vel;
  assign out_o.new_vel_z = stage_q[ST_OUT].ln[2].vel;

  // ---------------------------------------------------------------- assertions
  // input held off only when every stage is full and the output is stalled
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q) && !out_o.ready)
    else $error("input stalled with room in the pipeline");

  // x-lane divider remainder stays below the buffer
  a_rem_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_MUL-1] && stage_q[ST_MUL-1].ln[0].kind == SC_DIV
      |-> stage_q[ST_MUL-1].ln[0].rem < RW'(stage_q[ST_MUL-1].bufv))
    else $error("divider remainder out of range");

  // the scaled x-lane velocity magnitude stays at or below 2**32
  a_no_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_MUL] |-> stage_q[ST_MUL].ln[0].mag_prod[MW-1:QW] <= (MW-QW)'(33'h1_0000_0000))
    else $error("scaled velocity magnitude too large");

endmodule
